// ===== rtl/sit_pkg.sv =====
`default_nettype none

package sit_pkg;

   localparam int SIT_DEPTH     = 32;
   localparam int SIT_KEY_WIDTH = 32;

   // request codes
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic        req_type;
      logic [31:0] key;
      logic [4:0]  index;
   } sit_req_type;

   typedef struct packed {
      logic [31:0] read_key;
      logic [5:0]  entry_count;
      logic        is_empty;
      logic [1:0]  status;
   } sit_rsp_type;

   // control half of the carry handed from one cell to the next
   typedef struct packed {
      logic active;
      logic shifting;
   } sit_link_type;

endpackage

`default_nettype wire

// ===== rtl/sit_cell.sv =====
`default_nettype none

module sit_cell #(
   parameter int DEPTH     = sit_pkg::SIT_DEPTH,
   parameter int KEY_WIDTH = sit_pkg::SIT_KEY_WIDTH,
   parameter int INDEX     = 0
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            order_descending,
   input  wire [$clog2(DEPTH+1)-1:0]      count,
   input  sit_pkg::sit_link_type          link_in,
   input  wire [KEY_WIDTH-1:0]            link_key_in,
   output sit_pkg::sit_link_type          link_out,
   output logic [KEY_WIDTH-1:0]           link_key_out,
   output logic [KEY_WIDTH-1:0]           stored_key
);
   import sit_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   logic                 occupied;
   logic                 precedes;
   logic                 take;
   sit_link_type         link_ff;
   sit_link_type         link_in_next;
   logic [KEY_WIDTH-1:0] link_key_ff;
   logic [KEY_WIDTH-1:0] link_key_in_next;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] key_in;

   always_comb begin
      occupied = count > CW'(INDEX);
      precedes = order_descending ? (link_key_in > key_ff) : (link_key_in < key_ff);
      // empty slot, already shifting, or carried key goes in front of ours
      take = link_in.active && (!occupied || link_in.shifting || precedes);
      key_in = take ? link_key_in : key_ff;
      link_in_next.active   = link_in.active && occupied;
      link_in_next.shifting = take;
      link_key_in_next      = take ? key_ff : link_key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= '0;
      end else begin
         link_ff <= link_in_next;
      end
      link_key_ff <= link_key_in_next;
      key_ff      <= key_in;
   end

   assign link_out     = link_ff;
   assign link_key_out = link_key_ff;
   assign stored_key   = key_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_insert_table.sv =====
`default_nettype none

// Sorted key table built as a row of cells, position 0 first.
// Requests come on req_data with start; one is taken at a clock edge where start
// is high and busy is low. Each request gives exactly one result word on rsp_data,
// shown for one cycle with rsp_strobe; the receiver cannot stall and must take it.
// A read (or an insert into a full table) answers in the cycle after it is taken,
// and busy stays low, so such requests can follow every cycle.
// An insert that fits is injected at cell 0 and walks down the row one cell per
// cycle; a cell either keeps its key or swaps it for the carried one, and from the
// insertion point on every cell shifts its key up. The carry lands in the first
// free cell, and the insert answers once the carry has landed, with busy high
// meanwhile. The length of the walk along the row sets when it answers.
// csr_wr_en writes the order bit (0 ascending, 1 descending); write it only while
// idle. Keys stored earlier are not re-sorted.
// Reset empties the table and selects ascending order; key storage is not cleared.
module sorted_insert_table #(
   parameter int DEPTH     = sit_pkg::SIT_DEPTH,
   parameter int KEY_WIDTH = sit_pkg::SIT_KEY_WIDTH
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  sit_pkg::sit_req_type req_data,
   output logic                 rsp_strobe,
   output sit_pkg::sit_rsp_type rsp_data,
   input  wire                  csr_wr_en,
   input  wire                  csr_wr_data
);
   import sit_pkg::*;

   localparam int CW   = $clog2(DEPTH+1);
   localparam int IW   = $clog2(DEPTH);
   localparam int CMPW = (CW > 5) ? CW : 5;

   typedef enum logic {ST_IDLE, ST_INSERT} state_type;

   state_type            state_ff;
   logic                 order_ff;
   logic [CW-1:0]        count_ff;
   logic [CW-1:0]        step_ff;
   sit_link_type         inject_ff;
   logic [KEY_WIDTH-1:0] inject_key_ff;
   logic                 rsp_valid_ff;
   sit_rsp_type          rsp_ff;

   sit_link_type         link_ctl [DEPTH+1];
   logic [KEY_WIDTH-1:0] link_key [DEPTH+1];
   logic [KEY_WIDTH-1:0] cell_key [DEPTH];

   logic                 accept;
   logic                 full;
   logic                 in_range;
   logic [CMPW-1:0]      idx_ext;
   logic [CW-1:0]        count_inc;

   always_comb begin
      accept    = start && (state_ff == ST_IDLE);
      full      = count_ff == CW'(DEPTH);
      idx_ext   = CMPW'(req_data.index);
      in_range  = idx_ext < CMPW'(count_ff);
      count_inc = count_ff + 1'b1;
   end

   assign link_ctl[0] = inject_ff;
   assign link_key[0] = inject_key_ff;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      sit_cell #(
         .DEPTH     (DEPTH),
         .KEY_WIDTH (KEY_WIDTH),
         .INDEX     (g)
      ) u_cell (
         .clock            (clock),
         .reset            (reset),
         .order_descending (order_ff),
         .count            (count_ff),
         .link_in          (link_ctl[g]),
         .link_key_in      (link_key[g]),
         .link_out         (link_ctl[g+1]),
         .link_key_out     (link_key[g+1]),
         .stored_key       (cell_key[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         order_ff     <= 1'b0;
         count_ff     <= '0;
         step_ff      <= '0;
         inject_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         inject_ff    <= '0;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (req_data.req_type == REQ_READ) begin
                     rsp_valid_ff         <= 1'b1;
                     rsp_ff.read_key      <= in_range ? 32'(cell_key[idx_ext[IW-1:0]]) : '0;
                     rsp_ff.entry_count   <= 6'(count_ff);
                     rsp_ff.is_empty      <= count_ff == '0;
                     rsp_ff.status        <= in_range ? STATUS_OK : STATUS_RANGE;
                  end else if (full) begin
                     rsp_valid_ff         <= 1'b1;
                     rsp_ff.read_key      <= '0;
                     rsp_ff.entry_count   <= 6'(count_ff);
                     rsp_ff.is_empty      <= count_ff == '0;
                     rsp_ff.status        <= STATUS_FULL;
                  end else begin
                     state_ff           <= ST_INSERT;
                     step_ff            <= '0;
                     inject_ff.active   <= 1'b1;
                     inject_ff.shifting <= 1'b0;
                     inject_key_ff      <= KEY_WIDTH'(req_data.key);
                  end
               end
            end
            ST_INSERT: begin
               step_ff <= step_ff + 1'b1;
               // carry reaches the first free cell on this cycle
               if (step_ff == count_ff) begin
                  state_ff           <= ST_IDLE;
                  count_ff           <= count_inc;
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.read_key    <= '0;
                  rsp_ff.entry_count <= 6'(count_inc);
                  rsp_ff.is_empty    <= 1'b0;
                  rsp_ff.status      <= STATUS_OK;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy       = state_ff == ST_INSERT;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // the carry always lands before running off the end of the row
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !link_ctl[DEPTH].active)
      else $error("insert carry passed the last cell");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count moved by other than one");

   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.req_type == REQ_INSERT && !full |=> busy && !rsp_strobe)
      else $error("insert did not start a walk");

   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status == STATUS_FULL |-> count_ff == CW'(DEPTH))
      else $error("full status with room left");

endmodule

`default_nettype wire

// ===== verif/sorted_insert_table_checker.sv =====
`default_nettype none

module sorted_insert_table_checker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire                  busy,
   input  sit_pkg::sit_req_type req_data,
   input  wire                  rsp_strobe,
   input  sit_pkg::sit_rsp_type rsp_data,
   input  wire                  csr_wr_en,
   input  wire                  csr_wr_data,
   output int                   fail_count,
   output int                   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   localparam int REPORT_CAP = 200;

   logic [SIT_KEY_WIDTH-1:0] table_keys [SIT_DEPTH];
   int                       key_total = 0;
   logic                     descending = 1'b0;
   sit_rsp_type              expected_words [$];
   int                       errors = 0;
   int                       reports = 0;

   function automatic bit comes_first(logic [SIT_KEY_WIDTH-1:0] a,
                                      logic [SIT_KEY_WIDTH-1:0] b);
      return descending ? (a > b) : (a < b);
   endfunction

   // walks the table like the software insertion does and returns the word it should answer
   function sit_rsp_type apply_request(sit_req_type r);
      sit_rsp_type w;
      int          pos;
      int          i;
      w = '0;
      if (r.req_type == REQ_INSERT) begin
         if (key_total >= SIT_DEPTH) begin
            w.status = STATUS_FULL;
         end else begin
            pos = 0;
            while (pos < key_total && !comes_first(r.key, table_keys[pos]))
               pos++;
            for (i = key_total; i > pos; i--)
               table_keys[i] = table_keys[i-1];
            table_keys[pos] = r.key;
            key_total++;
         end
      end else if (int'(r.index) < key_total) begin
         w.read_key = table_keys[r.index];
      end else begin
         w.status = STATUS_RANGE;
      end
      w.entry_count = key_total[5:0];
      w.is_empty    = (key_total == 0);
      return w;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         // keep the log bounded when the block is badly off
         if (reports < REPORT_CAP) begin
            reports++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      sit_rsp_type want;
      if (reset) begin
         key_total  = 0;
         descending = 1'b0;
         expected_words.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_words.size() == 0) begin
               errors++;
               if (reports < REPORT_CAP) begin
                  reports++;
                  $display("%0t ns: result word with nothing expected, expected none, got %0h",
                           $time, rsp_data);
               end
            end else begin
               want = expected_words.pop_front();
               check_field("read_key", want.read_key, rsp_data.read_key);
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_data.entry_count));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_data.is_empty));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
         if (start && !busy)
            expected_words.push_back(apply_request(req_data));
         if (csr_wr_en)
            descending = csr_wr_data;
      end
      fail_count    <= errors;
      pending_count <= expected_words.size();
   end

endmodule

`default_nettype wire

// ===== verif/sorted_insert_table_tb.sv =====
`default_nettype none

module sorted_insert_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sit_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES      = 12;
   localparam int PHASE_WORDS = 125;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        start       = 1'b0;
   sit_req_type req_data    = '0;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;
   wire         busy;
   wire         rsp_strobe;
   sit_rsp_type rsp_data;
   int          fail_count;
   int          pending_count;
   int          stall_cycles = 0;
   int          inserts_sent = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sorted_insert_table dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   sorted_insert_table_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // nothing moving on either channel for too long means a hang
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("sorted_insert_table test failed");
            $finish;
         end
      end
   end

   function automatic sit_req_type make_req(logic kind, logic [31:0] key, logic [4:0] index);
      sit_req_type r;
      r.req_type = kind;
      r.key      = key;
      r.index    = index;
      return r;
   endfunction

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2, 3, 4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      case ($urandom_range(0, 19))
         12, 13, 14, 15, 16, 17: return $urandom_range(1, 3);
         18:                     return $urandom_range(4, 10);
         19:                     return $urandom_range(20, 60);
         default:                return 0;
      endcase
   endfunction

   // start stays high across back-to-back words; it only drops for a gap or in wait_idle
   task automatic issue_word(sit_req_type w, int gap);
      start    <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      if (w.req_type == REQ_INSERT && inserts_sent < SIT_DEPTH)
         inserts_sent++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle(int extra);
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending_count != 0 || busy)
         @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic set_order(logic descending);
      wait_idle(4);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= descending;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      sit_req_type w;
      logic        order;
      bit          quiet;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table: reads are out of range
      issue_word(make_req(REQ_READ, 32'h0, 5'd0), 0);
      issue_word(make_req(REQ_READ, 32'hffff_ffff, 5'd31), 2);
      // ascending, with a duplicate key and both key extremes
      issue_word(make_req(REQ_INSERT, 32'd5, 5'd31), 0);
      issue_word(make_req(REQ_INSERT, 32'h0, 5'd0), 0);
      issue_word(make_req(REQ_INSERT, 32'hffff_ffff, 5'd17), 1);
      issue_word(make_req(REQ_INSERT, 32'd5, 5'd10), 0);
      issue_word(make_req(REQ_READ, 32'h0, 5'd0), 0);
      issue_word(make_req(REQ_READ, 32'hffff_ffff, 5'd1), 0);
      issue_word(make_req(REQ_READ, 32'h0, 5'd2), 3);
      issue_word(make_req(REQ_READ, 32'h0, 5'd3), 0);
      issue_word(make_req(REQ_READ, 32'h0, 5'd4), 0);
      // descending with keys already stored: no re-sort
      set_order(1'b1);
      issue_word(make_req(REQ_INSERT, 32'd7, 5'd0), 0);
      issue_word(make_req(REQ_INSERT, 32'hffff_ffff, 5'd31), 0);
      issue_word(make_req(REQ_INSERT, 32'h0, 5'd5), 2);
      issue_word(make_req(REQ_READ, 32'h0, 5'd0), 0);
      issue_word(make_req(REQ_READ, 32'h0, 5'd6), 0);
      issue_word(make_req(REQ_READ, 32'h0, 5'd7), 1);
      issue_word(make_req(REQ_READ, 32'hffff_ffff, 5'd8), 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         order = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
         set_order(order);
         quiet = (phase % 4 == 2);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            // sparse inserts spread the fill over the first phases, then keep hitting full
            if ($urandom_range(0, 15) == 0) begin
               w = make_req(REQ_INSERT, pick_key(), 5'($urandom));
            end else if (inserts_sent == 0 || $urandom_range(0, 3) == 0) begin
               w = make_req(REQ_READ, $urandom, 5'($urandom));
            end else begin
               w = make_req(REQ_READ, $urandom, 5'($urandom_range(0, inserts_sent - 1)));
            end
            issue_word(w, quiet ? 0 : pick_gap());
         end
      end

      wait_idle(40);
      if (fail_count == 0) begin
         $display("sorted_insert_table test passed");
      end else begin
         $display("sorted_insert_table test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
